// ----- rtl/fpalu_pkg.sv -----
// ----------------------------------------------------------------------------
// fpalu_pkg
// Shared operation codes, field widths and float-format constants for the
// Q16.16 arithmetic unit.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned WORD_W = 32;

	localparam logic [OP_W-1:0] OP_MUL = 2'd0;
	localparam logic [OP_W-1:0] OP_DIV = 2'd1;
	localparam logic [OP_W-1:0] OP_F2Q = 2'd2;
	localparam logic [OP_W-1:0] OP_ABS = 2'd3;

	// IEEE single-precision layout
	localparam int unsigned FLT_MAN_W  = 23;
	localparam int unsigned FLT_EXP_W  = 8;
	localparam int signed   FLT_BIAS_M = 150;   // exponent bias plus mantissa width

endpackage

// ----- rtl/fixed_point_16_16_alu_core.sv -----
// ----------------------------------------------------------------------------
// fixed_point_16_16_alu_core
// Pipelined signed fixed-point unit: multiply, divide, float-to-fixed, abs.
// A request passes the stage-1 register, the restoring divide chain and the
// output register; chain depth NST = ceil((32 + FRAC_BITS) / DIV_STEPS).
// Throughput: one request per cycle; the whole pipe holds while the output
// register is full and not taken. Reset clears all valid bits asynchronously.
// ----------------------------------------------------------------------------
module fixed_point_16_16_alu_core
	import fpalu_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned DIV_STEPS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result
	output logic        m_tuser    // [0] divide_by_zero
);

	localparam int unsigned QW  = WORD_W + FRAC_BITS;
	localparam int unsigned NST = (QW + DIV_STEPS - 1) / DIV_STEPS;
	localparam int unsigned DW  = NST * DIV_STEPS;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input decode
	logic [OP_W-1:0]   op_in;
	logic [WORD_W-1:0] a_in, b_in, ma_in, mb_in, f2q_in, abs_in;
	logic [FLT_EXP_W-1:0] ex_in;
	logic [WORD_W-1:0] man_in;
	logic signed [9:0] sh_in;
	logic [9:0]        nsh_in;

	assign op_in = s_tuser;
	assign a_in  = s_tdata[31:0];
	assign b_in  = s_tdata[63:32];
	assign ma_in = a_in[WORD_W-1] ? (WORD_W'(0) - a_in) : a_in;
	assign mb_in = b_in[WORD_W-1] ? (WORD_W'(0) - b_in) : b_in;
	assign abs_in = ma_in;

	// Float to fixed: shift hidden-bit mantissa by exp - 150 + FRAC_BITS
	assign ex_in  = a_in[FLT_MAN_W +: FLT_EXP_W];
	assign man_in = WORD_W'({(ex_in != '0), a_in[FLT_MAN_W-1:0]});
	assign sh_in  = $signed({2'b00, ex_in}) - 10'(FLT_BIAS_M) + 10'(FRAC_BITS);
	assign nsh_in = 10'(-sh_in);

	always_comb begin
		logic [WORD_W-1:0] m;
		if (sh_in < 0) begin
			m = (nsh_in >= 10'd32) ? '0 : (man_in >> nsh_in[4:0]);
		end else begin
			m = (sh_in >= 10'sd32) ? '0 : (man_in << sh_in[4:0]);
		end
		f2q_in = a_in[WORD_W-1] ? (WORD_W'(0) - m) : m;
	end

	// Stage 1: operand magnitudes, product, simple results
	logic                     vld_s1, neg_s1, dz_s1;
	logic [OP_W-1:0]          op_s1;
	logic [WORD_W-1:0]        mb_s1, oth_s1;
	logic [DW-1:0]            dq_s1;
	logic signed [2*WORD_W-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= op_in;
			neg_s1  <= a_in[WORD_W-1] ^ b_in[WORD_W-1];
			dz_s1   <= (b_in == '0);
			mb_s1   <= mb_in;
			dq_s1   <= DW'({ma_in, FRAC_BITS'(0)});
			prod_s1 <= $signed(a_in) * $signed(b_in);
			oth_s1  <= (op_in == OP_F2Q) ? f2q_in : abs_in;
		end
	end

	// Divide chain: DIV_STEPS restoring steps per stage
	logic            vld_s [0:NST];
	logic            neg_s [0:NST];
	logic            dz_s  [0:NST];
	logic [OP_W-1:0] op_s  [0:NST];
	logic [WORD_W-1:0] mb_s  [0:NST];
	logic [WORD_W-1:0] oth_s [0:NST];
	logic [WORD_W-1:0] rem_s [0:NST];
	logic [DW-1:0]     dq_s  [0:NST];

	assign vld_s[0] = vld_s1;
	assign neg_s[0] = neg_s1;
	assign dz_s[0]  = dz_s1;
	assign op_s[0]  = op_s1;
	assign mb_s[0]  = mb_s1;
	assign rem_s[0] = '0;
	assign dq_s[0]  = dq_s1;
	// multiply result is resolved on entry to the chain
	assign oth_s[0] = (op_s1 == OP_MUL) ?
		WORD_W'(prod_s1 >>> FRAC_BITS) : oth_s1;

	for (genvar k = 1; k <= NST; k++) begin : g_div
		logic [WORD_W-1:0] rem_nx;
		logic [DW-1:0]     dq_nx;

		always_comb begin
			logic [WORD_W:0] r;
			rem_nx = rem_s[k-1];
			dq_nx  = dq_s[k-1];
			for (int i = 0; i < DIV_STEPS; i++) begin
				r     = {rem_nx, dq_nx[DW-1]};
				dq_nx = {dq_nx[DW-2:0], 1'b0};
				if (r >= {1'b0, mb_s[k-1]}) begin
					r        = r - {1'b0, mb_s[k-1]};
					dq_nx[0] = 1'b1;
				end
				rem_nx = r[WORD_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k] <= neg_s[k-1];
				dz_s[k]  <= dz_s[k-1];
				op_s[k]  <= op_s[k-1];
				mb_s[k]  <= mb_s[k-1];
				oth_s[k] <= oth_s[k-1];
				rem_s[k] <= rem_nx;
				dq_s[k]  <= dq_nx;
			end
		end
	end

	// Output register: sign fixup and result select
	logic [WORD_W-1:0] q_fin, res_fin;
	logic              dz_fin;

	assign q_fin  = dq_s[NST][WORD_W-1:0];
	assign dz_fin = (op_s[NST] == OP_DIV) && dz_s[NST];

	always_comb begin
		if (op_s[NST] == OP_DIV) begin
			if (dz_s[NST]) begin
				res_fin = '0;
			end else begin
				res_fin = neg_s[NST] ? (WORD_W'(0) - q_fin) : q_fin;
			end
		end else begin
			res_fin = oth_s[NST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res_fin;
			m_tuser <= dz_fin;
		end
	end

endmodule

// ----- rtl/fpalu_chk.sv -----
// ----------------------------------------------------------------------------
// fpalu_chk
// Port-level checks for the fixed-point unit, bound to the top level.
// ----------------------------------------------------------------------------
module fpalu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// stalled output request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output request changed while stalled");

	// an empty output register never blocks the input
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a zero-divisor flag always comes with a zero result
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("divide-by-zero result not zero");

endmodule

bind fixed_point_16_16_alu_core fpalu_chk u_fpalu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
